// ----- hw/rtl/stepper_ramp_pulse_generator_unit_defines.svh -----
// assertion macros shared by the stepper ramp pulse generator rtl
`ifndef STEPPER_RAMP_PULSE_GENERATOR_UNIT_DEFINES_SVH
`define STEPPER_RAMP_PULSE_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SRPG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SRPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/srpg_pkg.sv -----
// shared types and constants of the stepper ramp pulse generator
package srpg_pkg;

   localparam int RATE_W    = 20;
   localparam int POS_W     = 32;
   localparam int CSR_IDX_W = 2;
   localparam int DIV_CNT_W = $clog2(RATE_W + 1);

   localparam int TICKS_PER_SECOND_DEF = 1000000;
   localparam int RATE_STEP_DEF        = 2;

   localparam logic [RATE_W-1:0] MIN_RATE_RST = 20'd100;
   localparam logic [RATE_W-1:0] MAX_RATE_RST = 20'd1000;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RATE = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MOVE,
      ST_DIV,
      ST_RESULT
   } srpg_state_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic move_fin;
      logic load_out;
   } srpg_cmd_type;

   typedef struct packed {
      logic move_start;
      logic need_div;
      logic div_busy;
      logic div_done;
   } srpg_status_type;

endpackage

// ----- hw/rtl/srpg_div.sv -----
// radix-2 restoring divider: constant dividend over the step rate
module srpg_div #(
   parameter int DIVIDEND = srpg_pkg::TICKS_PER_SECOND_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [srpg_pkg::RATE_W-1:0] divisor,
   output logic [srpg_pkg::RATE_W-1:0] quotient,
   output logic                        busy,
   output logic                        done
);
   import srpg_pkg::*;

   localparam logic [RATE_W-1:0]    DIVIDEND_V = RATE_W'(DIVIDEND);
   localparam logic [DIV_CNT_W-1:0] LAST_CNT   = DIV_CNT_W'(RATE_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RATE_W-1:0]    rem_ff, rem_in;
   logic [RATE_W-1:0]    quo_ff, quo_in;
   logic [RATE_W-1:0]    den_ff, den_in;

   logic [RATE_W:0]      shifted;
   logic [RATE_W:0]      trial;
   logic                 fits;

   assign shifted = {rem_ff, quo_ff[RATE_W-1]};
   assign trial   = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = DIVIDEND_V;
         // a zero rate waits as long as a rate of one
         den_in  = (divisor == '0) ? RATE_W'(1) : divisor;
      end else if (busy_ff) begin
         rem_in = fits ? trial[RATE_W-1:0] : shifted[RATE_W-1:0];
         quo_in = {quo_ff[RATE_W-2:0], fits};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == LAST_CNT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign busy     = busy_ff;
   assign done     = done_ff;

endmodule

// ----- hw/rtl/srpg_dp.sv -----
// datapath: move setup, step timing, rate ramp, settings and result register
`include "stepper_ramp_pulse_generator_unit_defines.svh"

module srpg_dp #(
   parameter int TICKS_PER_SECOND = srpg_pkg::TICKS_PER_SECOND_DEF,
   parameter int RATE_STEP        = srpg_pkg::RATE_STEP_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  srpg_pkg::srpg_cmd_type         cmd,
   output srpg_pkg::srpg_status_type      status,
   input  logic                           req_mode,
   input  logic [srpg_pkg::POS_W-1:0]     req_target_position,
   input  logic                           csr_write,
   input  logic [srpg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [srpg_pkg::RATE_W-1:0]    csr_data,
   output logic                           rsp_step_pulse,
   output logic                           rsp_direction,
   output logic                           rsp_busy_res,
   output logic                           rsp_move_done,
   output logic                           rsp_rejected,
   output logic [srpg_pkg::POS_W-1:0]     rsp_current_position,
   output logic [srpg_pkg::RATE_W-1:0]    rsp_current_rate
);
   import srpg_pkg::*;

   localparam logic [RATE_W:0]   STEP_WIDE = (RATE_W + 1)'(RATE_STEP);
   localparam logic [RATE_W-1:0] STEP_N    = RATE_W'(RATE_STEP);

   // latched request beat
   logic                mode_ff, mode_in;
   logic [POS_W-1:0]    target_ff, target_in;

   logic [RATE_W-1:0]   min_rate_ff, min_rate_in;
   logic [RATE_W-1:0]   max_rate_ff, max_rate_in;

   logic [POS_W-1:0]    position_ff, position_in;
   logic [POS_W-1:0]    destination_ff, destination_in;
   logic [POS_W-1:0]    total_ff, total_in;
   logic [POS_W-1:0]    index_ff, index_in;
   logic [POS_W-1:0]    half_ff, half_in;
   logic [POS_W-1:0]    decel_ff, decel_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic [RATE_W-1:0]   wait_ff, wait_in;
   logic                backward_ff, backward_in;
   logic                moving_ff, moving_in;
   logic [RATE_W-2:0]   ramp_ff, ramp_in;
   logic                pulse_ff, pulse_in;
   logic                done_ff, done_in;
   logic                rej_ff, rej_in;

   logic                fwd;
   logic [POS_W-1:0]    diff;
   logic [RATE_W-1:0]   span;
   logic [POS_W-1:0]    ramp_ext;
   logic [RATE_W-1:0]   wait_dec;
   logic                wait_end;
   logic                all_done;
   logic                move_start;
   logic                need_div;
   logic                ramp_up;
   logic                ramp_down;
   logic [RATE_W:0]     rate_sum;
   logic [RATE_W-1:0]   rate_up;
   logic [RATE_W-1:0]   rate_dn;
   logic [RATE_W-1:0]   rate_next;
   logic [RATE_W-1:0]   div_quo;
   logic                div_busy;
   logic                div_done;

   assign fwd      = target_ff > position_ff;
   assign diff     = fwd ? (target_ff - position_ff) : (position_ff - target_ff);
   assign span     = (max_rate_ff >= min_rate_ff) ? (max_rate_ff - min_rate_ff) : '0;
   assign ramp_ext = {{(POS_W - RATE_W + 1){1'b0}}, ramp_ff};

   assign wait_dec = (wait_ff != '0) ? (wait_ff - RATE_W'(1)) : '0;
   assign wait_end = (wait_dec == '0);
   assign all_done = index_ff >= total_ff;

   assign move_start = mode_ff && !moving_ff;
   assign need_div   = !mode_ff && moving_ff && wait_end && !all_done;

   assign ramp_up   = (rate_ff <= max_rate_ff) && (index_ff < half_ff);
   assign ramp_down = (rate_ff > min_rate_ff) && (index_ff > half_ff)
                      && (index_ff >= decel_ff);
   assign rate_sum  = {1'b0, rate_ff} + STEP_WIDE;
   assign rate_up   = rate_sum[RATE_W] ? '1 : rate_sum[RATE_W-1:0];
   assign rate_dn   = (rate_ff > STEP_N) ? (rate_ff - STEP_N) : '0;
   assign rate_next = ramp_up ? rate_up : (ramp_down ? rate_dn : rate_ff);

   srpg_div #(
      .DIVIDEND (TICKS_PER_SECOND)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.exec && need_div),
      .divisor  (rate_ff),
      .quotient (div_quo),
      .busy     (div_busy),
      .done     (div_done)
   );

   always_comb begin
      status.move_start = move_start;
      status.need_div   = need_div;
      status.div_busy   = div_busy;
      status.div_done   = div_done;
   end

   always_comb begin
      min_rate_in = min_rate_ff;
      max_rate_in = max_rate_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MIN_RATE: min_rate_in = csr_data;
            CSR_MAX_RATE: max_rate_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      mode_in        = mode_ff;
      target_in      = target_ff;
      position_in    = position_ff;
      destination_in = destination_ff;
      total_in       = total_ff;
      index_in       = index_ff;
      half_in        = half_ff;
      decel_in       = decel_ff;
      rate_in        = rate_ff;
      wait_in        = wait_ff;
      backward_in    = backward_ff;
      moving_in      = moving_ff;
      ramp_in        = ramp_ff;
      pulse_in       = pulse_ff;
      done_in        = done_ff;
      rej_in         = rej_ff;

      if (cmd.accept) begin
         mode_in   = req_mode;
         target_in = req_target_position;
      end

      if (cmd.exec) begin
         pulse_in = 1'b0;
         done_in  = 1'b0;
         rej_in   = 1'b0;
         if (mode_ff) begin
            if (moving_ff) begin
               rej_in = 1'b1;
            end else begin
               backward_in    = !fwd;
               total_in       = diff;
               half_in        = diff >> 1;
               ramp_in        = span[RATE_W-1:1];
               destination_in = target_ff;
               index_in       = '0;
               wait_in        = '0;
               if (diff == '0) begin
                  position_in = target_ff;
                  rate_in     = '0;
                  done_in     = 1'b1;
               end else begin
                  rate_in   = min_rate_ff;
                  moving_in = 1'b1;
               end
            end
         end else if (moving_ff) begin
            wait_in = wait_dec;
            if (wait_end) begin
               if (all_done) begin
                  position_in = destination_ff;
                  moving_in   = 1'b0;
                  rate_in     = '0;
                  done_in     = 1'b1;
               end else begin
                  // wait for the next step comes from the divider
                  pulse_in = 1'b1;
                  rate_in  = rate_next;
                  index_in = index_ff + POS_W'(1);
               end
            end
         end
      end

      if (cmd.move_fin) begin
         decel_in = (ramp_ext > total_ff) ? half_ff : (total_ff - ramp_ext);
      end

      if (div_done) begin
         wait_in = div_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_rate_ff    <= MIN_RATE_RST;
         max_rate_ff    <= MAX_RATE_RST;
         position_ff    <= '0;
         destination_ff <= '0;
         total_ff       <= '0;
         index_ff       <= '0;
         half_ff        <= '0;
         decel_ff       <= '0;
         rate_ff        <= '0;
         wait_ff        <= '0;
         backward_ff    <= 1'b0;
         moving_ff      <= 1'b0;
      end else begin
         min_rate_ff    <= min_rate_in;
         max_rate_ff    <= max_rate_in;
         position_ff    <= position_in;
         destination_ff <= destination_in;
         total_ff       <= total_in;
         index_ff       <= index_in;
         half_ff        <= half_in;
         decel_ff       <= decel_in;
         rate_ff        <= rate_in;
         wait_ff        <= wait_in;
         backward_ff    <= backward_in;
         moving_ff      <= moving_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      target_ff <= target_in;
      ramp_ff   <= ramp_in;
      pulse_ff  <= pulse_in;
      done_ff   <= done_in;
      rej_ff    <= rej_in;
   end

   // result register, loaded once per beat
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_step_pulse       <= pulse_ff;
         rsp_direction        <= backward_ff;
         rsp_busy_res         <= moving_ff;
         rsp_move_done        <= done_ff;
         rsp_rejected         <= rej_ff;
         rsp_current_position <= position_ff;
         rsp_current_rate     <= moving_ff ? rate_ff : '0;
      end
   end

   `SRPG_ASSERT_NOW(a_moving_has_steps, clock, reset, moving_ff, total_ff != '0, "move without steps")
   `SRPG_ASSERT_NOW(a_index_in_range, clock, reset, moving_ff, index_ff <= total_ff, "step index past total")
   `SRPG_ASSERT_NOW(a_wait_only_moving, clock, reset, wait_ff != '0, moving_ff, "step wait while idle")

endmodule

// ----- hw/rtl/srpg_ctrl.sv -----
// controller: sequences one beat through execute, move setup, divide and result
`include "stepper_ramp_pulse_generator_unit_defines.svh"

module srpg_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output srpg_pkg::srpg_cmd_type    cmd,
   input  srpg_pkg::srpg_status_type status
);
   import srpg_pkg::*;

   srpg_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.move_start) state_in = ST_MOVE;
            else if (status.need_div) state_in = ST_DIV;
            else state_in = ST_RESULT;
         end
         ST_MOVE: begin
            state_in = ST_RESULT;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.accept   = 1'b0;
      cmd.exec     = 1'b0;
      cmd.move_fin = 1'b0;
      cmd.load_out = 1'b0;
      req_stall    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_EXEC:   cmd.exec     = 1'b1;
         ST_MOVE:   cmd.move_fin = 1'b1;
         ST_DIV:    ;
         ST_RESULT: cmd.load_out = out_free;
         default:   ;
      endcase
   end

   // result beat stays until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `SRPG_ASSERT_NEXT(a_accept_to_exec, clock, reset, cmd.accept, state_ff == ST_EXEC, "accept did not start execute")
   `SRPG_ASSERT_NOW(a_div_done_in_div, clock, reset, status.div_done, state_ff == ST_DIV, "divider finished outside divide state")
   `SRPG_ASSERT_NOW(a_div_runs, clock, reset, state_ff == ST_DIV, status.div_busy || status.div_done, "divide state with idle divider")
   `SRPG_ASSERT_NEXT(a_load_sets_valid, clock, reset, cmd.load_out, rsp_valid_ff, "result load lost")

endmodule

// ----- hw/rtl/stepper_ramp_pulse_generator_unit.sv -----
// top level of the stepper ramp pulse generator
//
// req_ channel: one beat is either a one-microsecond tick (req_mode 0) or a
// move to the absolute position req_target_position (req_mode 1). A beat is
// taken when req_valid is high and req_stall low; one beat is worked at a time.
// rsp_ channel: exactly one result beat per request beat, in order, held in an
// output register until rsp_valid is high and rsp_stall low.
// csr_ channel: index 0 writes min_rate, index 1 writes max_rate, others are
// dropped; csr_ready is always high. Write only while no beat is in flight.
// A tick without a step or a rejected move goes from execute straight to the
// result state, an accepted move passes through the move setup state, and a
// tick that issues a step waits in the divide state while the 20-step bit-serial
// divider works out the next wait. The next request is taken in the cycle
// after the result is loaded, even while that result still waits behind
// rsp_stall; a stalled result holds the following beat in the result state
// until the register frees.
// Reset clears position, the move and rsp_valid and loads the
// default rates (min 100, max 1000 steps per second).
module stepper_ramp_pulse_generator_unit #(
   parameter int TICKS_PER_SECOND = srpg_pkg::TICKS_PER_SECOND_DEF,
   parameter int RATE_STEP        = srpg_pkg::RATE_STEP_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_mode,
   input  logic [srpg_pkg::POS_W-1:0]     req_target_position,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_step_pulse,
   output logic                           rsp_direction,
   output logic                           rsp_busy_res,
   output logic                           rsp_move_done,
   output logic                           rsp_rejected,
   output logic [srpg_pkg::POS_W-1:0]     rsp_current_position,
   output logic [srpg_pkg::RATE_W-1:0]    rsp_current_rate,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [srpg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [srpg_pkg::RATE_W-1:0]    csr_data
);
   import srpg_pkg::*;

   srpg_cmd_type    cmd;
   srpg_status_type status;

   assign csr_ready = 1'b1;

   srpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   srpg_dp #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND),
      .RATE_STEP        (RATE_STEP)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_mode             (req_mode),
      .req_target_position  (req_target_position),
      .csr_write            (csr_valid && csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .rsp_step_pulse       (rsp_step_pulse),
      .rsp_direction        (rsp_direction),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_move_done        (rsp_move_done),
      .rsp_rejected         (rsp_rejected),
      .rsp_current_position (rsp_current_position),
      .rsp_current_rate     (rsp_current_rate)
   );

endmodule
